### hdl/adstat_pkg.sv
// Shared types, widths and codes for the binned Anderson-Darling statistic block.
`default_nettype none

package adstat_pkg;

   localparam int COUNT_BITS         = 24;
   localparam int FRAC_BITS_DEFAULT  = 32;

   localparam int NN_W   = COUNT_BITS + 1;
   localparam int MID_W  = COUNT_BITS + 2;
   localparam int POOL_W = COUNT_BITS + 3;
   localparam int M_W    = COUNT_BITS + 3;
   localparam int L_W    = COUNT_BITS + 1;
   localparam int B_W    = COUNT_BITS + 4;

   // Largest product: term numerator, final numerator or final denominator
   localparam int TERM_NUM_W  = 5 * COUNT_BITS + 9;
   localparam int FINAL_NUM_W = 2 * COUNT_BITS + 66;
   localparam int DEN_W       = 4 * COUNT_BITS + 4;
   localparam int MUL_W_A     = (TERM_NUM_W > FINAL_NUM_W) ? TERM_NUM_W : FINAL_NUM_W;
   localparam int MUL_W       = (MUL_W_A > DEN_W) ? MUL_W_A : DEN_W;
   localparam int MUL_B_W     = 2 * COUNT_BITS + 4;

   localparam int             DIV_STEPS = 64;
   localparam int             DCNT_W    = 7;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_ZDIV  = 2'd2;
   localparam logic [1:0] STATUS_SAT   = 2'd3;

   localparam int ERR_ZDIV_BIT = 0;
   localparam int ERR_SAT_BIT  = 1;

   localparam logic CSR_TOTAL_A = 1'b0;
   localparam logic CSR_TOTAL_B = 1'b1;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count_a;
      logic [COUNT_BITS-1:0] count_b;
      logic                  last_bin;
   } req_type;

   typedef struct packed {
      logic [63:0] statistic;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [3:0] {
      MS_P  = 4'd0,
      MS_T  = 4'd1,
      MS_X  = 4'd2,
      MS_Y  = 4'd3,
      MS_SQ = 4'd4,
      MS_E  = 4'd5,
      MS_NN = 4'd6,
      MS_DA = 4'd7,
      MS_DB = 4'd8,
      MS_U  = 4'd9,
      MS_V  = 4'd10,
      MS_W  = 4'd11
   } mul_sel_type;

   typedef enum logic [3:0] {
      OP_NONE      = 4'd0,
      OP_LOAD      = 4'd1,
      OP_PREP      = 4'd2,
      OP_ZDIV      = 4'd3,
      OP_DEN_P     = 4'd4,
      OP_DEN_SUB   = 4'd5,
      OP_TMP_LOAD  = 4'd6,
      OP_TMP_DIFF  = 4'd7,
      OP_TMP_ADD   = 4'd8,
      OP_ACC_TERM  = 4'd9,
      OP_ADV       = 4'd10,
      OP_RES_EMPTY = 4'd11,
      OP_RES_FINAL = 4'd12
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        mul_go;
      mul_sel_type mul_sel;
      logic        div_go;
      logic        div_final;
      logic        side;
   } cmd_type;

   typedef struct packed {
      logic mul_busy;
      logic div_busy;
      logic active;
      logic b_zero;
      logic b_big;
      logic den_bad;
      logic last;
      logic empty;
   } sts_type;

endpackage

`default_nettype wire

### hdl/adstat_dp.sv
// Datapath: bin state, shift-add multiplier, restoring divider and result register.
`default_nettype none

module adstat_dp #(
   parameter int FRAC_BITS = adstat_pkg::FRAC_BITS_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  adstat_pkg::cmd_type                  cmd,
   output adstat_pkg::sts_type                  sts,
   input  adstat_pkg::req_type                  req_data,
   input  wire                                  csr_valid,
   input  wire                                  csr_index,
   input  wire [adstat_pkg::COUNT_BITS-1:0]     csr_data,
   output adstat_pkg::rsp_type                  rsp_data
);

   localparam int CB     = adstat_pkg::COUNT_BITS;
   localparam int NN_W   = adstat_pkg::NN_W;
   localparam int MID_W  = adstat_pkg::MID_W;
   localparam int POOL_W = adstat_pkg::POOL_W;
   localparam int M_W    = adstat_pkg::M_W;
   localparam int L_W    = adstat_pkg::L_W;
   localparam int B_W    = adstat_pkg::B_W;
   localparam int MW     = adstat_pkg::MUL_W;
   localparam int MB     = adstat_pkg::MUL_B_W;
   localparam int DW     = adstat_pkg::DEN_W;
   localparam int XW     = MW + FRAC_BITS;
   localparam int HW     = XW - 64;
   localparam int CW     = (HW > DW + 1) ? HW : DW + 1;

   // configuration and accumulation state
   logic [CB-1:0]     ta_ff, ta_in, tb_ff, tb_in;
   logic [MID_W-1:0]  mid_a_ff, mid_a_in, mid_b_ff, mid_b_in;
   logic [POOL_W-1:0] pool_ff, pool_in;
   logic [63:0]       sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic              stop_ff, stop_in;
   logic [1:0]        err_ff, err_in;
   logic              den_bad_ff, den_bad_in;
   // bin scratch
   logic [CB-1:0]     fa_ff, fa_in, fb_ff, fb_in;
   logic              last_ff, last_in;
   logic [L_W-1:0]    l_ff, l_in;
   logic [B_W-1:0]    b_ff, b_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [MW-1:0]     tmp_ff, tmp_in;
   // multiplier
   logic [MW-1:0]     acc_ff, acc_in, ma_ff, ma_in;
   logic [MB-1:0]     mb_ff, mb_in;
   // divider
   logic [DW-1:0]     rem_ff, rem_in;
   logic [63:0]       lo_ff, lo_in, q_ff, q_in;
   logic              over_ff, over_in;
   logic [adstat_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   // result
   logic [63:0]       stat_ff, stat_in;
   logic [1:0]        status_ff, status_in;

   logic [NN_W-1:0]   nn;
   logic [NN_W:0]     nn2;
   logic [L_W-1:0]    lsum;
   logic [M_W-1:0]    m_side;
   logic [CB-1:0]     n_side;
   logic [MW-1:0]     op_a;
   logic [MB-1:0]     op_b;
   logic [XW-1:0]     xw;
   logic [CW-1:0]     hi_ext;
   logic              hi_big;
   logic [DW:0]       rem2, rem_sub;
   logic              ge;
   logic [64:0]       term_sum;
   logic [1:0]        err_f;
   logic [POOL_W-1:0] pool_next;

   assign nn     = NN_W'(ta_ff) + NN_W'(tb_ff);
   assign nn2    = {nn, 1'b0};
   assign lsum   = L_W'(fa_ff) + L_W'(fb_ff);
   assign m_side = cmd.side ? (M_W'(mid_b_ff) + M_W'(fb_ff)) : (M_W'(mid_a_ff) + M_W'(fa_ff));
   assign n_side = cmd.side ? tb_ff : ta_ff;

   assign xw      = cmd.div_final ? XW'(acc_ff) : {acc_ff, {FRAC_BITS{1'b0}}};
   assign hi_ext  = CW'(xw[XW-1:64]);
   assign hi_big  = hi_ext >= CW'(den_ff);
   assign rem2    = {rem_ff, lo_ff[63]};
   assign ge      = rem2 >= {1'b0, den_ff};
   assign rem_sub = rem2 - {1'b0, den_ff};

   assign term_sum  = {1'b0, cmd.side ? sum_b_ff : sum_a_ff} + {1'b0, q_ff};
   assign err_f     = err_ff | (over_ff ? 2'b10 : 2'b00);
   assign pool_next = pool_ff + POOL_W'({l_ff, 1'b0});

   always_comb begin
      op_a = MW'(b_ff);
      op_b = MB'(nn2 - (NN_W+1)'(b_ff));
      case (cmd.mul_sel)
         adstat_pkg::MS_P:  begin op_a = MW'(b_ff);     op_b = MB'(nn2 - (NN_W+1)'(b_ff)); end
         adstat_pkg::MS_T:  begin op_a = MW'(nn);       op_b = MB'(l_ff);     end
         adstat_pkg::MS_X:  begin op_a = MW'(m_side);   op_b = MB'(nn);       end
         adstat_pkg::MS_Y:  begin op_a = MW'(n_side);   op_b = MB'(b_ff);     end
         adstat_pkg::MS_SQ: begin op_a = tmp_ff;        op_b = tmp_ff[MB-1:0]; end
         adstat_pkg::MS_E:  begin op_a = acc_ff;        op_b = MB'(l_ff);     end
         adstat_pkg::MS_NN: begin op_a = MW'(nn);       op_b = MB'(nn);       end
         adstat_pkg::MS_DA: begin op_a = acc_ff;        op_b = MB'(ta_ff);    end
         adstat_pkg::MS_DB: begin op_a = acc_ff;        op_b = MB'(tb_ff);    end
         adstat_pkg::MS_U:  begin op_a = MW'(sum_a_ff); op_b = MB'(tb_ff);    end
         adstat_pkg::MS_V:  begin op_a = MW'(sum_b_ff); op_b = MB'(ta_ff);    end
         adstat_pkg::MS_W:  begin op_a = tmp_ff;        op_b = MB'(nn - NN_W'(1)); end
         default: ;
      endcase
   end

   always_comb begin
      ta_in = ta_ff;       tb_in = tb_ff;
      mid_a_in = mid_a_ff; mid_b_in = mid_b_ff; pool_in = pool_ff;
      sum_a_in = sum_a_ff; sum_b_in = sum_b_ff;
      stop_in = stop_ff;   err_in = err_ff;   den_bad_in = den_bad_ff;
      fa_in = fa_ff;       fb_in = fb_ff;     last_in = last_ff;
      l_in = l_ff;         b_in = b_ff;       den_in = den_ff;   tmp_in = tmp_ff;
      acc_in = acc_ff;     ma_in = ma_ff;     mb_in = mb_ff;
      rem_in = rem_ff;     lo_in = lo_ff;     q_in = q_ff;
      over_in = over_ff;   cnt_in = cnt_ff;
      stat_in = stat_ff;   status_in = status_ff;

      if (csr_valid) begin
         unique case (csr_index)
            adstat_pkg::CSR_TOTAL_A: ta_in = csr_data;
            adstat_pkg::CSR_TOTAL_B: tb_in = csr_data;
            default: ;
         endcase
      end

      // shift-add multiplier, stops once the multiplier operand runs out of ones
      if (cmd.mul_go) begin
         acc_in = '0;
         ma_in  = op_a;
         mb_in  = op_b;
      end else if (mb_ff != '0) begin
         if (mb_ff[0]) acc_in = acc_ff + ma_ff;
         ma_in = ma_ff << 1;
         mb_in = mb_ff >> 1;
      end

      // restoring divider; a high part at or above the divisor means overflow
      if (cmd.div_go) begin
         if (hi_big) begin
            q_in    = '1;
            over_in = 1'b1;
            cnt_in  = '0;
         end else begin
            rem_in  = hi_ext[DW-1:0];
            lo_in   = xw[63:0];
            q_in    = '0;
            over_in = 1'b0;
            cnt_in  = adstat_pkg::DCNT_W'(adstat_pkg::DIV_STEPS);
         end
      end else if (cnt_ff != '0) begin
         rem_in = ge ? rem_sub[DW-1:0] : rem2[DW-1:0];
         q_in   = {q_ff[62:0], ge};
         lo_in  = lo_ff << 1;
         cnt_in = cnt_ff - 1'b1;
      end

      case (cmd.op) inside
         adstat_pkg::OP_LOAD: begin
            fa_in   = req_data.count_a;
            fb_in   = req_data.count_b;
            last_in = req_data.last_bin;
         end
         adstat_pkg::OP_PREP: begin
            l_in = lsum;
            b_in = B_W'(pool_ff) + B_W'(lsum);
         end
         adstat_pkg::OP_ZDIV: err_in[adstat_pkg::ERR_ZDIV_BIT] = 1'b1;
         adstat_pkg::OP_DEN_P: begin
            den_in     = acc_ff[DW-1:0];
            den_bad_in = 1'b0;
         end
         adstat_pkg::OP_DEN_SUB: begin
            if (den_ff <= acc_ff[DW-1:0]) begin
               den_bad_in = 1'b1;
               err_in[adstat_pkg::ERR_ZDIV_BIT] = 1'b1;
            end else begin
               den_in = den_ff - acc_ff[DW-1:0];
            end
         end
         adstat_pkg::OP_TMP_LOAD: tmp_in = acc_ff;
         adstat_pkg::OP_TMP_DIFF: tmp_in = (tmp_ff >= acc_ff) ? tmp_ff - acc_ff : acc_ff - tmp_ff;
         adstat_pkg::OP_TMP_ADD:  tmp_in = tmp_ff + acc_ff;
         adstat_pkg::OP_ACC_TERM: begin
            if (over_ff || term_sum[64]) begin
               err_in[adstat_pkg::ERR_SAT_BIT] = 1'b1;
               if (cmd.side) sum_b_in = '1;
               else          sum_a_in = '1;
            end else begin
               if (cmd.side) sum_b_in = term_sum[63:0];
               else          sum_a_in = term_sum[63:0];
            end
         end
         adstat_pkg::OP_ADV: begin
            mid_a_in = mid_a_ff + MID_W'({fa_ff, 1'b0});
            mid_b_in = mid_b_ff + MID_W'({fb_ff, 1'b0});
            pool_in  = pool_next;
            if (pool_next >= POOL_W'(nn2)) stop_in = 1'b1;
         end
         adstat_pkg::OP_RES_EMPTY, adstat_pkg::OP_RES_FINAL: begin
            if (cmd.op == adstat_pkg::OP_RES_EMPTY) begin
               stat_in   = '0;
               status_in = adstat_pkg::STATUS_EMPTY;
            end else begin
               stat_in = q_ff;
               if (err_f[adstat_pkg::ERR_SAT_BIT])       status_in = adstat_pkg::STATUS_SAT;
               else if (err_f[adstat_pkg::ERR_ZDIV_BIT]) status_in = adstat_pkg::STATUS_ZDIV;
               else                                      status_in = adstat_pkg::STATUS_OK;
            end
            // start the next histogram pair
            mid_a_in = '0; mid_b_in = '0; pool_in = '0;
            sum_a_in = '0; sum_b_in = '0; stop_in = 1'b0; err_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ta_ff <= '0;    tb_ff <= '0;
         mid_a_ff <= '0; mid_b_ff <= '0; pool_ff <= '0;
         sum_a_ff <= '0; sum_b_ff <= '0;
         stop_ff <= 1'b0; err_ff <= '0; den_bad_ff <= 1'b0;
         mb_ff <= '0;    cnt_ff <= '0;
      end else begin
         ta_ff <= ta_in;       tb_ff <= tb_in;
         mid_a_ff <= mid_a_in; mid_b_ff <= mid_b_in; pool_ff <= pool_in;
         sum_a_ff <= sum_a_in; sum_b_ff <= sum_b_in;
         stop_ff <= stop_in;   err_ff <= err_in;   den_bad_ff <= den_bad_in;
         mb_ff <= mb_in;       cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      fa_ff <= fa_in;   fb_ff <= fb_in;   last_ff <= last_in;
      l_ff <= l_in;     b_ff <= b_in;     den_ff <= den_in;   tmp_ff <= tmp_in;
      acc_ff <= acc_in; ma_ff <= ma_in;
      rem_ff <= rem_in; lo_ff <= lo_in;   q_ff <= q_in;       over_ff <= over_in;
      stat_ff <= stat_in; status_ff <= status_in;
   end

   assign sts.mul_busy = (mb_ff != '0);
   assign sts.div_busy = (cnt_ff != '0);
   assign sts.active   = !stop_ff && (pool_ff < POOL_W'(nn2));
   assign sts.b_zero   = (b_ff == '0);
   assign sts.b_big    = (b_ff >= B_W'(nn2));
   assign sts.den_bad  = den_bad_ff;
   assign sts.last     = last_ff;
   assign sts.empty    = (ta_ff == '0) || (tb_ff == '0);

   assign rsp_data.statistic = stat_ff;
   assign rsp_data.status    = status_ff;

endmodule

`default_nettype wire

### hdl/adstat_ctl.sv
// Controller: sequences the datapath through one bin and the final division.
`default_nettype none

module adstat_ctl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output adstat_pkg::cmd_type  cmd,
   input  adstat_pkg::sts_type  sts
);

   typedef enum logic [20:0] {
      S_IDLE  = 21'd1,
      S_PREP  = 21'd2,
      S_CHECK = 21'd4,
      S_P     = 21'd8,
      S_T     = 21'd16,
      S_DCHK  = 21'd32,
      S_X     = 21'd64,
      S_Y     = 21'd128,
      S_SQ    = 21'd256,
      S_E     = 21'd512,
      S_DIV   = 21'd1024,
      S_ADV   = 21'd2048,
      S_FIN   = 21'd4096,
      S_NN    = 21'd8192,
      S_DA    = 21'd16384,
      S_DB    = 21'd32768,
      S_U     = 21'd65536,
      S_V     = 21'd131072,
      S_W     = 21'd262144,
      S_FDIV  = 21'd524288,
      S_RES   = 21'd1048576
   } state_type;

   state_type state_ff, state_in;
   logic      issued_ff, issued_in;
   logic      side_ff, side_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      res_fire;

   always_comb begin
      state_in      = state_ff;
      issued_in     = issued_ff;
      side_in       = side_ff;
      res_fire      = 1'b0;
      cmd.op        = adstat_pkg::OP_NONE;
      cmd.mul_go    = 1'b0;
      cmd.mul_sel   = adstat_pkg::MS_P;
      cmd.div_go    = 1'b0;
      cmd.div_final = 1'b0;
      cmd.side      = side_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = adstat_pkg::OP_LOAD;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.op   = adstat_pkg::OP_PREP;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!sts.active || sts.b_zero) begin
               state_in = S_FIN;
            end else if (sts.b_big) begin
               cmd.op   = adstat_pkg::OP_ZDIV;
               state_in = S_ADV;
            end else begin
               state_in = S_P;
            end
         end
         S_P: begin
            if (!issued_ff) begin
               cmd.mul_go = 1'b1; cmd.mul_sel = adstat_pkg::MS_P; issued_in = 1'b1;
            end else if (!sts.mul_busy) begin
               cmd.op = adstat_pkg::OP_DEN_P; issued_in = 1'b0; state_in = S_T;
            end
         end
         S_T: begin
            if (!issued_ff) begin
               cmd.mul_go = 1'b1; cmd.mul_sel = adstat_pkg::MS_T; issued_in = 1'b1;
            end else if (!sts.mul_busy) begin
               cmd.op = adstat_pkg::OP_DEN_SUB; issued_in = 1'b0; state_in = S_DCHK;
            end
         end
         S_DCHK: begin
            side_in  = 1'b0;
            state_in = sts.den_bad ? S_ADV : S_X;
         end
         S_X: begin
            if (!issued_ff) begin
               cmd.mul_go = 1'b1; cmd.mul_sel = adstat_pkg::MS_X; issued_in = 1'b1;
            end else if (!sts.mul_busy) begin
               cmd.op = adstat_pkg::OP_TMP_LOAD; issued_in = 1'b0; state_in = S_Y;
            end
         end
         S_Y: begin
            if (!issued_ff) begin
               cmd.mul_go = 1'b1; cmd.mul_sel = adstat_pkg::MS_Y; issued_in = 1'b1;
            end else if (!sts.mul_busy) begin
               cmd.op = adstat_pkg::OP_TMP_DIFF; issued_in = 1'b0; state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (!issued_ff) begin
               cmd.mul_go = 1'b1; cmd.mul_sel = adstat_pkg::MS_SQ; issued_in = 1'b1;
            end else if (!sts.mul_busy) begin
               issued_in = 1'b0; state_in = S_E;
            end
         end
         S_E: begin
            if (!issued_ff) begin
               cmd.mul_go = 1'b1; cmd.mul_sel = adstat_pkg::MS_E; issued_in = 1'b1;
            end else if (!sts.mul_busy) begin
               issued_in = 1'b0; state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!issued_ff) begin
               cmd.div_go = 1'b1; issued_in = 1'b1;
            end else if (!sts.div_busy) begin
               cmd.op    = adstat_pkg::OP_ACC_TERM;
               issued_in = 1'b0;
               if (side_ff) begin
                  state_in = S_ADV;
               end else begin
                  side_in  = 1'b1;
                  state_in = S_X;
               end
            end
         end
         S_ADV: begin
            cmd.op   = adstat_pkg::OP_ADV;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!sts.last)      state_in = S_IDLE;
            else if (sts.empty) state_in = S_RES;
            else                state_in = S_NN;
         end
         S_NN: begin
            if (!issued_ff) begin
               cmd.mul_go = 1'b1; cmd.mul_sel = adstat_pkg::MS_NN; issued_in = 1'b1;
            end else if (!sts.mul_busy) begin
               issued_in = 1'b0; state_in = S_DA;
            end
         end
         S_DA: begin
            if (!issued_ff) begin
               cmd.mul_go = 1'b1; cmd.mul_sel = adstat_pkg::MS_DA; issued_in = 1'b1;
            end else if (!sts.mul_busy) begin
               issued_in = 1'b0; state_in = S_DB;
            end
         end
         S_DB: begin
            if (!issued_ff) begin
               cmd.mul_go = 1'b1; cmd.mul_sel = adstat_pkg::MS_DB; issued_in = 1'b1;
            end else if (!sts.mul_busy) begin
               cmd.op = adstat_pkg::OP_DEN_P; issued_in = 1'b0; state_in = S_U;
            end
         end
         S_U: begin
            if (!issued_ff) begin
               cmd.mul_go = 1'b1; cmd.mul_sel = adstat_pkg::MS_U; issued_in = 1'b1;
            end else if (!sts.mul_busy) begin
               cmd.op = adstat_pkg::OP_TMP_LOAD; issued_in = 1'b0; state_in = S_V;
            end
         end
         S_V: begin
            if (!issued_ff) begin
               cmd.mul_go = 1'b1; cmd.mul_sel = adstat_pkg::MS_V; issued_in = 1'b1;
            end else if (!sts.mul_busy) begin
               cmd.op = adstat_pkg::OP_TMP_ADD; issued_in = 1'b0; state_in = S_W;
            end
         end
         S_W: begin
            if (!issued_ff) begin
               cmd.mul_go = 1'b1; cmd.mul_sel = adstat_pkg::MS_W; issued_in = 1'b1;
            end else if (!sts.mul_busy) begin
               issued_in = 1'b0; state_in = S_FDIV;
            end
         end
         S_FDIV: begin
            cmd.div_final = 1'b1;
            if (!issued_ff) begin
               cmd.div_go = 1'b1; issued_in = 1'b1;
            end else if (!sts.div_busy) begin
               issued_in = 1'b0; state_in = S_RES;
            end
         end
         S_RES: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = sts.empty ? adstat_pkg::OP_RES_EMPTY : adstat_pkg::OP_RES_FINAL;
               res_fire = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || res_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         side_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### hdl/binned_anderson_darling_statistic_top.sv
// Top level of the binned two-sample Anderson-Darling statistic block.
// One transaction on req_ is one histogram bin; a bin with last_bin set yields one rsp_
// transaction carrying the statistic (unsigned, FRAC_BITS fraction bits) and a status.
// Totals are written over csr_ (index 0 first histogram, 1 second). The user must write them
// only while the block is idle; the block itself does not enforce this. Bins are processed
// one at a time by a shared shift-add multiplier, which stops at the highest set bit of its
// multiplier operand, and a 64-step restoring divider. A bin that contributes terms uses two
// divisions plus ten multiplications; the last bin adds six multiplications and one more
// division. A new bin is accepted while a finished result still waits in the output
// register.
`default_nettype none

module binned_anderson_darling_statistic_top #(
   parameter int FRAC_BITS = adstat_pkg::FRAC_BITS_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  adstat_pkg::req_type               req_data,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output adstat_pkg::rsp_type               rsp_data,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire                               csr_index,
   input  wire [adstat_pkg::COUNT_BITS-1:0]  csr_data
);

   adstat_pkg::cmd_type cmd;
   adstat_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   adstat_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   adstat_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### hdl/adstat_chk.sv
// Port-level checker for the Anderson-Darling statistic block, with its bind.
`default_nettype none

module adstat_chk (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_valid,
   input wire                               req_ready,
   input wire                               rsp_valid,
   input wire                               rsp_ready,
   input adstat_pkg::rsp_type               rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // an empty histogram always reports zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == adstat_pkg::STATUS_EMPTY |-> rsp_data.statistic == '0)
      else $error("empty status with nonzero statistic");

   // one bin at a time: the block is busy right after a transaction
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted on consecutive cycles");

endmodule

bind binned_anderson_darling_statistic_top adstat_chk u_adstat_chk (.*);

`default_nettype wire

### tb/binned_anderson_darling_statistic_checker.sv
// Checker: predicts the Anderson-Darling statistic per histogram pair and compares results.
`timescale 1ns / 1ps
`default_nettype none

module binned_anderson_darling_statistic_checker #(
   parameter int FRAC_BITS = adstat_pkg::FRAC_BITS_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   input  wire                               req_ready,
   input  adstat_pkg::req_type               req_data,
   input  wire                               rsp_valid,
   input  wire                               rsp_ready,
   input  adstat_pkg::rsp_type               rsp_data,
   input  wire                               csr_valid,
   input  wire                               csr_ready,
   input  wire                               csr_index,
   input  wire [adstat_pkg::COUNT_BITS-1:0]  csr_data,
   output int                                fail_count,
   output int                                pending
);

   localparam int WW = 320;
   typedef logic [WW-1:0] wide_t;

   logic [adstat_pkg::COUNT_BITS-1:0] tot_a, tot_b;
   logic [adstat_pkg::MID_W-1:0]      mid_a, mid_b;
   logic [adstat_pkg::POOL_W-1:0]     pool;
   logic [63:0]                       sum_a, sum_b;
   logic                              stopped;
   logic [1:0]                        err;
   adstat_pkg::rsp_type               expected_q[$];

   // floor(num * 2^frac / den); flag and clamp when the quotient needs more than 64 bits
   function automatic logic [63:0] quotient64(wide_t num, wide_t den, int frac,
                                              output logic over);
      wide_t q;
      q = (num << frac) / den;
      over = |q[WW-1:64];
      return over ? '1 : q[63:0];
   endfunction

   task automatic fold_term(inout logic [63:0] sum, input logic [63:0] nn, m, n, b, l,
                            input wide_t den);
      wide_t x, y, d;
      logic over;
      logic [63:0] q;
      logic [64:0] s;
      x = wide_t'(nn) * wide_t'(m);
      y = wide_t'(n) * wide_t'(b);
      d = (x >= y) ? x - y : y - x;
      d = d * d * wide_t'(l);
      q = quotient64(d, den, FRAC_BITS, over);
      s = {1'b0, sum} + {1'b0, q};
      if (over || s[64]) begin
         sum = '1;
         err[adstat_pkg::ERR_SAT_BIT] = 1'b1;
      end else begin
         sum = s[63:0];
      end
   endtask

   task automatic clear_accum();
      mid_a = '0;
      mid_b = '0;
      pool = '0;
      sum_a = '0;
      sum_b = '0;
      stopped = 1'b0;
      err = '0;
   endtask

   task automatic take_bin(adstat_pkg::req_type item);
      logic [63:0] nn, fa, fb, l, b, ma, mb;
      wide_t p, t, den, num;
      logic over;
      adstat_pkg::rsp_type res;
      fa = 64'(item.count_a);
      fb = 64'(item.count_b);
      nn = 64'(tot_a) + 64'(tot_b);
      if (!stopped && 64'(pool) < 2 * nn) begin
         l = fa + fb;
         b = 64'(pool) + l;
         if (b != 0) begin
            if (b >= 2 * nn) begin
               err[adstat_pkg::ERR_ZDIV_BIT] = 1'b1;
            end else begin
               p = wide_t'(b) * wide_t'(2 * nn - b);
               t = wide_t'(nn) * wide_t'(l);
               if (p <= t) begin
                  err[adstat_pkg::ERR_ZDIV_BIT] = 1'b1;
               end else begin
                  den = p - t;
                  ma = 64'(mid_a) + fa;
                  mb = 64'(mid_b) + fb;
                  fold_term(sum_a, nn, ma, 64'(tot_a), b, l, den);
                  fold_term(sum_b, nn, mb, 64'(tot_b), b, l, den);
               end
            end
            mid_a = mid_a + adstat_pkg::MID_W'(2 * fa);
            mid_b = mid_b + adstat_pkg::MID_W'(2 * fb);
            pool = pool + adstat_pkg::POOL_W'(2 * l);
            if (64'(pool) >= 2 * nn) stopped = 1'b1;
         end
      end
      if (item.last_bin) begin
         if (tot_a == 0 || tot_b == 0) begin
            res.statistic = '0;
            res.status = adstat_pkg::STATUS_EMPTY;
         end else begin
            num = (wide_t'(sum_a) * wide_t'(tot_b) + wide_t'(sum_b) * wide_t'(tot_a))
                  * wide_t'(nn - 1);
            den = wide_t'(nn) * wide_t'(nn) * wide_t'(tot_a) * wide_t'(tot_b);
            res.statistic = quotient64(num, den, 0, over);
            if (over) err[adstat_pkg::ERR_SAT_BIT] = 1'b1;
            if (err[adstat_pkg::ERR_SAT_BIT]) res.status = adstat_pkg::STATUS_SAT;
            else if (err[adstat_pkg::ERR_ZDIV_BIT]) res.status = adstat_pkg::STATUS_ZDIV;
            else res.status = adstat_pkg::STATUS_OK;
         end
         expected_q = {expected_q, res};
         clear_accum();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tot_a = '0;
         tot_b = '0;
         clear_accum();
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == adstat_pkg::CSR_TOTAL_A) tot_a = csr_data;
            else tot_b = csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result transaction statistic %h status %0d",
                        $realtime, rsp_data.statistic, rsp_data.status);
               fail_count++;
            end else begin
               if (rsp_data.statistic !== expected_q[0].statistic) begin
                  $display("%0t: statistic mismatch expected %h actual %h", $realtime,
                           expected_q[0].statistic, rsp_data.statistic);
                  fail_count++;
               end
               if (rsp_data.status !== expected_q[0].status) begin
                  $display("%0t: status mismatch expected %0d actual %0d", $realtime,
                           expected_q[0].status, rsp_data.status);
                  fail_count++;
               end
               void'(expected_q.pop_front());
            end
         end
         if (req_valid && req_ready) take_bin(req_data);
      end
      pending = expected_q.size();
   end

endmodule

`default_nettype wire

### tb/binned_anderson_darling_statistic_top_test.sv
// Testbench top: drives bins, totals and result back-pressure, and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none

module binned_anderson_darling_statistic_top_test;

   localparam int CB          = adstat_pkg::COUNT_BITS;
   localparam int ITEM_TARGET = 1550;
   localparam int SETTLE      = 600;
   localparam int LONG_HOLD   = 3000;
   localparam int CYCLE_LIMIT = 8000000;
   localparam logic [CB-1:0] CMAX = '1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   adstat_pkg::req_type   req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   adstat_pkg::rsp_type   rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_index = adstat_pkg::CSR_TOTAL_A;
   logic [CB-1:0]         csr_data = '0;
   int                    fail_count, pending;
   int                    items = 0;
   int                    cycles = 0;
   bit                    idle_on = 1'b1;
   bit                    hold_req = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   binned_anderson_darling_statistic_top dut (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   binned_anderson_darling_statistic_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data, .fail_count, .pending
   );

   function automatic int draw_gap();
      if (!idle_on || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 16);
   endfunction

   task automatic send_bin(logic [CB-1:0] ca, cb, logic last);
      int gap;
      req_valid <= 1'b1;
      req_data <= '{count_a: ca, count_b: cb, last_bin: last};
      do @(posedge clock); while (!req_ready);
      items++;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid, then hold until no result is outstanding and the block sits idle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0 || !req_ready) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [CB-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_totals(logic [CB-1:0] ta, tb);
      drain();
      csr_write(adstat_pkg::CSR_TOTAL_A, ta);
      csr_write(adstat_pkg::CSR_TOTAL_B, tb);
   endtask

   function automatic logic [CB-1:0] pick_total();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return CMAX;
      if (r == 2) return CB'($urandom);
      if (r < 6) return CB'($urandom_range(1, 5000));
      return CB'($urandom_range(1, 60));
   endfunction

   // Well-formed pair: bins add up to the totals, optionally with ignored trailing bins.
   task automatic send_histogram(logic [CB-1:0] ta, tb);
      int nb, extra;
      logic [CB-1:0] rem_a, rem_b, ca, cb;
      nb = $urandom_range(1, 10);
      extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      rem_a = ta;
      rem_b = tb;
      for (int i = 0; i < nb; i++) begin
         if (i == nb - 1) begin
            ca = rem_a;
            cb = rem_b;
         end else begin
            ca = ($urandom_range(0, 5) == 0) ? '0 : CB'($urandom_range(0, rem_a));
            cb = ($urandom_range(0, 5) == 0) ? '0 : CB'($urandom_range(0, rem_b));
         end
         rem_a -= ca;
         rem_b -= cb;
         send_bin(ca, cb, (i == nb - 1) && extra == 0);
      end
      for (int i = 0; i < extra; i++)
         send_bin(CB'($urandom_range(0, 40)), CB'($urandom_range(0, 40)),
                  i == extra - 1);
   endtask

   // Receiver: random stalls per result, plus one long hold-off on request.
   initial begin
      int stall;
      bit held;
      held = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_req && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid && !(hold_req && !held)) @(posedge clock);
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int kind, nb;
      logic [CB-1:0] ta, tb;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero totals: every bin ignored, result reports an empty histogram
      send_bin('0, '0, 1'b1);
      send_bin(CMAX, CMAX, 1'b1);
      // Small pair with an empty leading bin and bins after the pooled sum is reached
      set_totals(CB'(3), CB'(5));
      send_bin(CB'(0), CB'(0), 1'b0);
      send_bin(CB'(1), CB'(2), 1'b0);
      send_bin(CB'(2), CB'(0), 1'b0);
      send_bin(CB'(0), CB'(3), 1'b0);
      send_bin(CB'(7), CB'(7), 1'b0);
      send_bin(CB'(0), CB'(0), 1'b1);
      // Term quotient overflow
      set_totals(CB'(1), CMAX);
      send_bin(CMAX, CB'(0), 1'b1);
      // Largest totals and counts
      set_totals(CMAX, CMAX);
      send_bin(CMAX, CMAX, 1'b1);
      // Second histogram empty
      set_totals(CB'(4), CB'(0));
      send_bin(CB'(2), CB'(0), 1'b1);
      // Counts that disagree with the totals: divisor not positive
      set_totals(CB'(2), CB'(2));
      send_bin(CB'(3), CB'(3), 1'b1);
      // Totals rewritten partway through a pair
      send_bin(CB'(1), CB'(1), 1'b0);
      set_totals(CB'(6), CB'(2));
      send_bin(CB'(1), CB'(1), 1'b0);
      send_bin(CB'(4), CB'(0), 1'b1);

      // Fill the block while the receiver holds off
      set_totals(CB'(1), CB'(1));
      hold_req = 1'b1;
      repeat (8) send_bin(CB'(1), CB'(1), 1'b1);
      drain();

      while (items < ITEM_TARGET) begin
         idle_on = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            ta = pick_total();
            tb = pick_total();
            set_totals(ta, tb);
            send_histogram(ta, tb);
         end else if (kind < 9) begin
            ta = CB'($urandom_range(0, 60));
            tb = CB'($urandom_range(0, 60));
            set_totals(ta, tb);
            nb = $urandom_range(1, 8);
            for (int i = 0; i < nb; i++)
               send_bin(CB'($urandom_range(0, 3 * ta + 2)),
                        CB'($urandom_range(0, 3 * tb + 2)),
                        $urandom_range(0, 3) == 0);
         end else begin
            set_totals(CB'($urandom), CB'($urandom));
            nb = $urandom_range(1, 3);
            for (int i = 0; i < nb; i++)
               send_bin(CB'($urandom), CB'($urandom), 1'($urandom));
         end
      end

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
